// ===== rtl/lalr_pkg.sv =====
// Package for the LALR parse step engine: beat structs, codes and FSM states.
// No dependencies.
package lalr_pkg;

  typedef enum logic [1:0] {
    CMD_TOKEN   = 2'd0,
    CMD_WR_ACT  = 2'd1,
    CMD_WR_PROD = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CLS_ORDINARY = 2'd0,
    CLS_LEXERR   = 2'd1,
    CLS_NOISE    = 2'd2,
    CLS_UNDEF    = 2'd3
  } cls_t;

  localparam logic [2:0] ACT_EMPTY  = 3'd0;
  localparam logic [2:0] ACT_SHIFT  = 3'd1;
  localparam logic [2:0] ACT_REDUCE = 3'd2;
  localparam logic [2:0] ACT_GOTO   = 3'd3;
  localparam logic [2:0] ACT_ACCEPT = 3'd4;

  localparam logic [2:0] RES_SHIFT   = 3'd0;
  localparam logic [2:0] RES_REDUCE  = 3'd1;
  localparam logic [2:0] RES_ELIM    = 3'd2;
  localparam logic [2:0] RES_ACCEPT  = 3'd3;
  localparam logic [2:0] RES_LEXERR  = 3'd4;
  localparam logic [2:0] RES_SYNTAX  = 3'd5;
  localparam logic [2:0] RES_INTERR  = 3'd6;

  localparam logic CFG_TRIM = 1'b0;
  localparam logic CFG_INIT = 1'b1;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] symbol;
    logic [1:0] token_class;
    logic [7:0] table_state;
    logic [2:0] action_kind;
    logic [8:0] action_target;
    logic [8:0] prod_index;
    logic [3:0] prod_length;
    logic [6:0] prod_head;
    logic       prod_unit;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] state_after;
    logic [8:0] production;
    logic [3:0] handle_count;
    logic [6:0] stack_depth;
    logic       last;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ACT_RD,
    ST_ACT_WAIT,
    ST_ACT_EVAL,
    ST_PROD_WAIT,
    ST_PROD_EVAL,
    ST_UNDER_WAIT,
    ST_GOTO_WAIT,
    ST_GOTO_EVAL
  } state_t;

endpackage

// ===== rtl/lalr_parse_step_engine_core.sv =====
// LALR parse step engine top level: sequencer over action, production and stack RAMs.
// Depends on lalr_pkg and lalr_ram.
// Sequence: a write, restart, noise or lexical error token is handled in idle, never busy;
// an ordinary token steps through action read, wait and evaluate states; each reduction
// adds production, stack and goto reads, gives its reduce beat, then reads the next action.
// Throughput: next item taken in the cycle of the final beat; busy meanwhile. No stalls.
// Reset: stack holds state 0; a clearing pass over all 32768 action entries runs busy.
module lalr_parse_step_engine_core #(
  parameter int NUM_STATES          = 256,
  parameter int NUM_SYMBOLS         = 128,
  parameter int NUM_PRODUCTIONS     = 512,
  parameter int STACK_DEPTH         = 64,
  parameter int MAX_STEPS_PER_TOKEN = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  lalr_pkg::in_beat_t  in_beat,
  output logic                result_valid,
  output lalr_pkg::out_beat_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data
);

  localparam int SW   = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int YW   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int PW   = (NUM_PRODUCTIONS > 1) ? $clog2(NUM_PRODUCTIONS) : 1;
  localparam int DW   = $clog2(STACK_DEPTH);
  localparam int AW   = SW + YW;
  localparam int ADEP = NUM_STATES * (1 << YW);
  localparam int NW   = $clog2(MAX_STEPS_PER_TOKEN + 1);

  lalr_pkg::state_t state, state_next;

  logic        trim_enable;
  logic [7:0]  initial_state;
  logic [6:0]  sym;
  logic [7:0]  tos;
  logic [6:0]  sp;
  logic [NW-1:0] steps;
  logic [AW-1:0] clr_addr;
  logic [8:0]  red_prod;
  logic [3:0]  red_len;
  logic [6:0]  red_head;
  logic        red_trim;

  logic          act_we;
  logic [AW-1:0] act_waddr, act_raddr;
  logic [11:0]   act_wdata, act_rdata;
  logic          act_rd_ok, act_rd_ok_q;
  logic          prod_we;
  logic [PW-1:0] prod_waddr, prod_raddr;
  logic [11:0]   prod_wdata, prod_rdata;
  logic          stk_we;
  logic [DW-1:0] stk_waddr, stk_raddr;
  logic [7:0]    stk_wdata, stk_rdata;

  logic [2:0]  akind;
  logic [8:0]  atgt;
  logic [6:0]  under_idx;

  logic        out_v;
  lalr_pkg::out_beat_t out_d;

  assign akind = act_rd_ok_q ? act_rdata[11:9] : lalr_pkg::ACT_EMPTY;
  assign atgt  = act_rdata[8:0];

  lalr_ram #(.WIDTH(12), .DEPTH(ADEP)) u_act (
    .clk(clk), .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
    .raddr(act_raddr), .rdata(act_rdata));
  lalr_ram #(.WIDTH(12), .DEPTH(NUM_PRODUCTIONS)) u_prod (
    .clk(clk), .we(prod_we), .waddr(prod_waddr), .wdata(prod_wdata),
    .raddr(prod_raddr), .rdata(prod_rdata));
  lalr_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata));

  assign busy      = (state != lalr_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_enable   <= 1'b0;
      initial_state <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        lalr_pkg::CFG_TRIM: trim_enable <= cfg_data[0];
        lalr_pkg::CFG_INIT: initial_state <= cfg_data;
        default: ;
      endcase
    end
  end

  // Read address for the action lookup / goto lookup, with range check.
  logic [7:0] lk_state;
  logic [6:0] lk_sym;
  always_comb begin
    lk_state = tos;
    lk_sym   = sym;
    if (state == lalr_pkg::ST_GOTO_WAIT) begin
      lk_state = stk_rdata;
      lk_sym   = red_head;
    end
    act_rd_ok = (32'(lk_state) < NUM_STATES) && (32'(lk_sym) < NUM_SYMBOLS);
    act_raddr = {lk_state[SW-1:0], lk_sym[YW-1:0]};
  end

  always_ff @(posedge clk) begin
    act_rd_ok_q <= act_rd_ok;
  end

  // Reduce checks on production entry.
  logic [3:0] p_len;
  logic [6:0] p_head;
  logic       p_trim;
  logic       p_bad;
  assign p_len  = prod_rdata[4:1];
  assign p_head = prod_rdata[11:5];
  assign p_trim = trim_enable && (p_len == 4'd1) && prod_rdata[0];
  always_comb begin
    if (p_trim) begin
      p_bad     = (sp < 7'd2);
      under_idx = sp - 7'd2;
    end else begin
      p_bad     = (sp <= 7'(p_len)) || (32'(sp) - 32'(p_len) + 1 > STACK_DEPTH);
      under_idx = sp - 7'd1 - 7'(p_len);
    end
  end

  always_comb begin
    state_next = state;
    act_we     = 1'b0;
    act_waddr  = {in_beat.table_state[SW-1:0], in_beat.symbol[YW-1:0]};
    act_wdata  = {in_beat.action_kind, in_beat.action_target};
    prod_we    = 1'b0;
    prod_waddr = in_beat.prod_index[PW-1:0];
    prod_wdata = {in_beat.prod_head, in_beat.prod_length, in_beat.prod_unit};
    prod_raddr = atgt[PW-1:0];
    stk_we     = 1'b0;
    stk_waddr  = sp[DW-1:0];
    stk_wdata  = atgt[7:0];
    stk_raddr  = under_idx[DW-1:0];
    out_v      = 1'b0;
    out_d      = '{result_kind: lalr_pkg::RES_INTERR, state_after: tos,
                   production: 9'd0, handle_count: 4'd0, stack_depth: sp, last: 1'b1};
    case (state)
      lalr_pkg::ST_CLEAR: begin
        act_we    = 1'b1;
        act_waddr = clr_addr;
        act_wdata = '0;
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = '0;
        if (32'(clr_addr) == ADEP - 1) state_next = lalr_pkg::ST_IDLE;
      end
      lalr_pkg::ST_IDLE: begin
        if (start) begin
          case (in_beat.cmd)
            lalr_pkg::CMD_WR_ACT: begin
              act_we = (32'(in_beat.table_state) < NUM_STATES) &&
                       (32'(in_beat.symbol) < NUM_SYMBOLS);
            end
            lalr_pkg::CMD_WR_PROD: begin
              prod_we = (32'(in_beat.prod_index) < NUM_PRODUCTIONS);
            end
            lalr_pkg::CMD_RESTART: begin
              stk_we    = 1'b1;
              stk_waddr = '0;
              stk_wdata = initial_state;
            end
            default: begin
              if (in_beat.token_class == lalr_pkg::CLS_LEXERR ||
                  in_beat.token_class == lalr_pkg::CLS_UNDEF) begin
                out_v = 1'b1;
                out_d.result_kind = lalr_pkg::RES_LEXERR;
              end else if (in_beat.token_class == lalr_pkg::CLS_ORDINARY) begin
                state_next = lalr_pkg::ST_ACT_RD;
              end
            end
          endcase
        end
      end
      lalr_pkg::ST_ACT_RD: state_next = lalr_pkg::ST_ACT_WAIT;
      lalr_pkg::ST_ACT_WAIT: state_next = lalr_pkg::ST_ACT_EVAL;
      lalr_pkg::ST_ACT_EVAL: begin
        state_next = lalr_pkg::ST_IDLE;
        out_v = 1'b1;
        case (akind)
          lalr_pkg::ACT_EMPTY: out_d.result_kind = lalr_pkg::RES_SYNTAX;
          lalr_pkg::ACT_ACCEPT: out_d.result_kind = lalr_pkg::RES_ACCEPT;
          lalr_pkg::ACT_SHIFT: begin
            if (32'(atgt) < NUM_STATES && 32'(sp) < STACK_DEPTH) begin
              stk_we = 1'b1;
              out_d.result_kind = lalr_pkg::RES_SHIFT;
              out_d.state_after = atgt[7:0];
              out_d.stack_depth = sp + 7'd1;
            end
          end
          lalr_pkg::ACT_REDUCE: begin
            if (32'(steps) < MAX_STEPS_PER_TOKEN - 1 && 32'(atgt) < NUM_PRODUCTIONS) begin
              out_v = 1'b0;
              state_next = lalr_pkg::ST_PROD_WAIT;
            end
          end
          default: ;
        endcase
      end
      lalr_pkg::ST_PROD_WAIT: begin
        prod_raddr = red_prod[PW-1:0];
        state_next = lalr_pkg::ST_PROD_EVAL;
      end
      lalr_pkg::ST_PROD_EVAL: begin
        if (p_bad) begin
          out_v = 1'b1;
          state_next = lalr_pkg::ST_IDLE;
        end else begin
          state_next = lalr_pkg::ST_UNDER_WAIT;
        end
      end
      lalr_pkg::ST_UNDER_WAIT: state_next = lalr_pkg::ST_GOTO_WAIT;
      lalr_pkg::ST_GOTO_WAIT: state_next = lalr_pkg::ST_GOTO_EVAL;
      lalr_pkg::ST_GOTO_EVAL: begin
        if (akind != lalr_pkg::ACT_GOTO || 32'(atgt) >= NUM_STATES) begin
          out_v = 1'b1;
          state_next = lalr_pkg::ST_IDLE;
        end else begin
          out_v = 1'b1;
          stk_we = 1'b1;
          stk_wdata = atgt[7:0];
          out_d.state_after = atgt[7:0];
          out_d.production  = red_prod;
          out_d.last        = 1'b0;
          if (red_trim) begin
            stk_waddr = DW'(sp - 7'd1);
            out_d.result_kind = lalr_pkg::RES_ELIM;
          end else begin
            stk_waddr = DW'(sp - 7'(red_len));
            out_d.result_kind  = lalr_pkg::RES_REDUCE;
            out_d.handle_count = red_len;
            out_d.stack_depth  = sp - 7'(red_len) + 7'd1;
          end
          state_next = lalr_pkg::ST_ACT_RD;
        end
      end
      default: state_next = lalr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lalr_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp           <= 7'd1;
      tos          <= '0;
      clr_addr     <= '0;
      steps        <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= out_v;
      if (state == lalr_pkg::ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == lalr_pkg::ST_IDLE && start) begin
        steps <= '0;
        sym   <= in_beat.symbol;
        if (in_beat.cmd == lalr_pkg::CMD_RESTART) begin
          sp  <= 7'd1;
          tos <= initial_state;
        end
      end
      if (state == lalr_pkg::ST_ACT_EVAL) begin
        red_prod <= atgt;
        if (out_v && out_d.result_kind == lalr_pkg::RES_SHIFT) begin
          sp  <= out_d.stack_depth;
          tos <= out_d.state_after;
        end
      end
      if (state == lalr_pkg::ST_PROD_EVAL) begin
        red_len  <= p_len;
        red_head <= p_head;
        red_trim <= p_trim;
      end
      if (state == lalr_pkg::ST_GOTO_EVAL && out_v && !out_d.last) begin
        sp    <= out_d.stack_depth;
        tos   <= out_d.state_after;
        steps <= steps + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= out_d;
  end

`ifndef ASSERT_OFF
  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.stack_depth != 7'd0 && 32'(result.stack_depth) <= STACK_DEPTH)
    else $error("stack depth out of range");
  a_reduce_not_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.result_kind == lalr_pkg::RES_REDUCE ||
                     result.result_kind == lalr_pkg::RES_ELIM) |-> !result.last)
    else $error("reduce marked last");
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> !busy)
    else $error("busy after final result");
  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    32'(steps) < MAX_STEPS_PER_TOKEN)
    else $error("step count beyond bound");
`endif

endmodule

// ===== rtl/lalr_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module lalr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== dv/lalr_parse_step_engine_core_tb.sv =====
// Testbench for lalr_parse_step_engine_core: loads small grammars, drives token streams
// and checks every result beat against an in-bench parse predictor. Depends on lalr_pkg and the core.
`timescale 1ns / 100ps

module lalr_parse_step_engine_core_tb;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int DRAIN_CYCLES = 800;
  localparam logic [2:0] ACT_UNDEF = 3'd7;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  lalr_pkg::in_beat_t  in_beat = '0;
  logic      result_valid;
  lalr_pkg::out_beat_t result;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_index = 1'b0;
  logic [7:0] cfg_data = '0;

  lalr_parse_step_engine_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_beat(in_beat),
    .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // parser copy
  logic [11:0] act_tbl [0:32767];
  logic [6:0]  prod_head [0:511];
  logic [3:0]  prod_len [0:511];
  logic        prod_unit [0:511];
  logic [7:0]  stk [0:63];
  int          sp;
  logic        trim_on;
  logic [7:0]  init_st;

  lalr_pkg::in_beat_t  token_q[$];
  lalr_pkg::out_beat_t pending_results[$];
  int        errors = 0;
  int        sent = 0;
  longint    cycles = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report(string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void push_res(logic [2:0] kind, logic [7:0] st, logic [8:0] prod,
                                   logic [3:0] hc, logic lst);
    lalr_pkg::out_beat_t r;
    r.result_kind  = kind;
    r.state_after  = st;
    r.production   = prod;
    r.handle_count = hc;
    r.stack_depth  = sp[6:0];
    r.last         = lst;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void predict_parse(lalr_pkg::in_beat_t b);
    logic [11:0] a, g;
    logic [7:0]  under;
    logic [8:0]  tgt;
    logic [3:0]  len;
    logic        trimmed;
    int          n;
    bit          done;
    n = 0;
    done = 0;
    case (b.cmd)
      lalr_pkg::CMD_WR_ACT:
        act_tbl[{b.table_state, b.symbol}] = {b.action_kind, b.action_target};
      lalr_pkg::CMD_WR_PROD: begin
        prod_head[b.prod_index] = b.prod_head;
        prod_len[b.prod_index]  = b.prod_length;
        prod_unit[b.prod_index] = b.prod_unit;
      end
      lalr_pkg::CMD_RESTART: begin
        stk[0] = init_st;
        sp = 1;
      end
      default: begin
        if (b.token_class == lalr_pkg::CLS_NOISE) return;
        if (b.token_class != lalr_pkg::CLS_ORDINARY) begin
          push_res(lalr_pkg::RES_LEXERR, stk[sp-1], '0, '0, 1'b1);
          return;
        end
        while (!done) begin
          a = act_tbl[{stk[sp-1], b.symbol}];
          tgt = a[8:0];
          done = 1;
          case (a[11:9])
            lalr_pkg::ACT_EMPTY: push_res(lalr_pkg::RES_SYNTAX, stk[sp-1], '0, '0, 1'b1);
            lalr_pkg::ACT_ACCEPT: push_res(lalr_pkg::RES_ACCEPT, stk[sp-1], '0, '0, 1'b1);
            lalr_pkg::ACT_SHIFT: begin
              if (tgt[8] || sp >= 64) begin
                push_res(lalr_pkg::RES_INTERR, stk[sp-1], '0, '0, 1'b1);
              end else begin
                stk[sp] = tgt[7:0];
                sp++;
                push_res(lalr_pkg::RES_SHIFT, tgt[7:0], '0, '0, 1'b1);
              end
            end
            lalr_pkg::ACT_REDUCE: begin
              len = prod_len[tgt];
              trimmed = trim_on && len == 1 && prod_unit[tgt];
              if (n >= 63 || (trimmed && sp < 2) ||
                  (!trimmed && (sp <= len || sp - len + 1 > 64))) begin
                push_res(lalr_pkg::RES_INTERR, stk[sp-1], '0, '0, 1'b1);
              end else begin
                under = trimmed ? stk[sp-2] : stk[sp-1-len];
                g = act_tbl[{under, prod_head[tgt]}];
                if (g[11:9] != lalr_pkg::ACT_GOTO || g[8]) begin
                  push_res(lalr_pkg::RES_INTERR, stk[sp-1], '0, '0, 1'b1);
                end else if (trimmed) begin
                  stk[sp-1] = g[7:0];
                  push_res(lalr_pkg::RES_ELIM, g[7:0], tgt, '0, 1'b0);
                  done = 0;
                end else begin
                  sp = sp - len;
                  stk[sp] = g[7:0];
                  sp++;
                  push_res(lalr_pkg::RES_REDUCE, g[7:0], tgt, len, 1'b0);
                  done = 0;
                end
              end
              n++;
            end
            default: push_res(lalr_pkg::RES_INTERR, stk[sp-1], '0, '0, 1'b1);
          endcase
        end
      end
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) predict_parse(in_beat);
      if (token_q.size() != 0 && (($urandom_range(99) >= 8) || (sent > 200 && sent < 320)))
          begin
        in_beat <= token_q.pop_front();
        start <= 1'b1;
        sent++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    lalr_pkg::out_beat_t e;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        e = pending_results.pop_front();
        if (result.result_kind !== e.result_kind)
          report($sformatf("kind %0d exp %0d", result.result_kind, e.result_kind));
        if (result.state_after !== e.state_after)
          report($sformatf("state %0d exp %0d", result.state_after, e.state_after));
        if (result.production !== e.production)
          report($sformatf("prod %0d exp %0d", result.production, e.production));
        if (result.handle_count !== e.handle_count)
          report($sformatf("handle %0d exp %0d", result.handle_count, e.handle_count));
        if (result.stack_depth !== e.stack_depth)
          report($sformatf("depth %0d exp %0d", result.stack_depth, e.stack_depth));
        if (result.last !== e.last)
          report($sformatf("last %0d exp %0d", result.last, e.last));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic lalr_pkg::in_beat_t noise_fill();
    lalr_pkg::in_beat_t b;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    b = raw[$bits(lalr_pkg::in_beat_t)-1:0];
    return b;
  endfunction

  task automatic add_act(int st, int sym, logic [2:0] kind, int tgt);
    lalr_pkg::in_beat_t b;
    b = noise_fill();
    b.cmd = lalr_pkg::CMD_WR_ACT;
    b.table_state = 8'(st);
    b.symbol = 7'(sym);
    b.action_kind = kind;
    b.action_target = 9'(tgt);
    token_q.insert(token_q.size(), b);
  endtask

  task automatic add_prod(int idx, int len, int head, logic unit);
    lalr_pkg::in_beat_t b;
    b = noise_fill();
    b.cmd = lalr_pkg::CMD_WR_PROD;
    b.prod_index = 9'(idx);
    b.prod_length = 4'(len);
    b.prod_head = 7'(head);
    b.prod_unit = unit;
    token_q.insert(token_q.size(), b);
  endtask

  task automatic add_tok(int sym, logic [1:0] cls);
    lalr_pkg::in_beat_t b;
    b = noise_fill();
    b.cmd = lalr_pkg::CMD_TOKEN;
    b.symbol = 7'(sym);
    b.token_class = cls;
    token_q.insert(token_q.size(), b);
  endtask

  task automatic add_restart();
    lalr_pkg::in_beat_t b;
    b = noise_fill();
    b.cmd = lalr_pkg::CMD_RESTART;
    token_q.insert(token_q.size(), b);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (token_q.size() != 0 || start || busy || pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [7:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == lalr_pkg::CFG_TRIM) trim_on = d[0];
    else init_st = d;
  endtask

  // small random grammar: states 0..7, terminals 0..5, nonterminals 6..9, productions 0..7
  task automatic build_grammar();
    int r, len;
    for (int p = 0; p < 8; p++) begin
      len = $urandom_range(3);
      add_prod(p, len, $urandom_range(6, 9), (len == 1) && ($urandom_range(1) == 1));
    end
    for (int s = 0; s < 8; s++) begin
      for (int y = 0; y < 6; y++) begin
        r = $urandom_range(99);
        if (r < 40)      add_act(s, y, lalr_pkg::ACT_SHIFT, $urandom_range(7));
        else if (r < 75) add_act(s, y, lalr_pkg::ACT_REDUCE, $urandom_range(7));
        else if (r < 85) add_act(s, y, lalr_pkg::ACT_EMPTY, $urandom_range(511));
        else if (r < 92) add_act(s, y, lalr_pkg::ACT_ACCEPT, $urandom_range(511));
        else if (r < 96) add_act(s, y, lalr_pkg::ACT_GOTO, $urandom_range(7));
        else             add_act(s, y, lalr_pkg::ACT_SHIFT, $urandom_range(256, 511));
      end
      for (int y = 6; y < 10; y++) begin
        if ($urandom_range(9) < 8) add_act(s, y, lalr_pkg::ACT_GOTO, $urandom_range(7));
        else add_act(s, y, $urandom_range(1) ? lalr_pkg::ACT_EMPTY : lalr_pkg::ACT_SHIFT,
                     $urandom_range(511));
      end
    end
  endtask

  task automatic random_sentences(int count);
    int made, r;
    made = 0;
    while (made < count) begin
      add_restart();
      if ($urandom_range(19) == 0)
        add_act($urandom_range(7), $urandom_range(5),
                $urandom_range(1) ? lalr_pkg::ACT_SHIFT : lalr_pkg::ACT_REDUCE,
                $urandom_range(7));
      repeat ($urandom_range(2, 14)) begin
        r = $urandom_range(99);
        if (r < 80)      add_tok($urandom_range(5), lalr_pkg::CLS_ORDINARY);
        else if (r < 85) add_tok($urandom_range(127), lalr_pkg::CLS_NOISE);
        else if (r < 88) add_tok($urandom_range(127),
                                 $urandom_range(1) ? lalr_pkg::CLS_LEXERR : lalr_pkg::CLS_UNDEF);
        else if (r < 92) add_tok($urandom_range(127), lalr_pkg::CLS_ORDINARY);
        else             add_tok($urandom_range(6, 9), lalr_pkg::CLS_ORDINARY);
        made++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 32768; i++) act_tbl[i] = '0;
    stk[0] = '0;
    sp = 1;
    trim_on = 1'b0;
    init_st = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    cfg_write(lalr_pkg::CFG_TRIM, 8'd0);
    cfg_write(lalr_pkg::CFG_INIT, 8'd0);

    // directed: shift, reduce with goto, accept, errors, step bound
    add_prod(511, 15, 127, 1'b1);
    add_prod(0, 1, 5, 1'b1);
    add_act(0, 0, lalr_pkg::ACT_SHIFT, 1);
    add_act(1, 1, lalr_pkg::ACT_REDUCE, 0);
    add_act(0, 5, lalr_pkg::ACT_GOTO, 2);
    add_act(2, 1, lalr_pkg::ACT_ACCEPT, 0);
    add_act(1, 2, lalr_pkg::ACT_REDUCE, 511);
    add_act(0, 3, lalr_pkg::ACT_GOTO, 4);
    add_act(0, 4, lalr_pkg::ACT_SHIFT, 300);
    add_act(1, 9, lalr_pkg::ACT_REDUCE, 0);
    add_act(2, 9, lalr_pkg::ACT_REDUCE, 0);
    add_act(255, 127, ACT_UNDEF, 511);
    add_tok(0, lalr_pkg::CLS_ORDINARY);
    add_tok(1, lalr_pkg::CLS_ORDINARY);
    add_tok(2, lalr_pkg::CLS_ORDINARY);
    add_tok(127, lalr_pkg::CLS_LEXERR);
    add_tok(0, lalr_pkg::CLS_UNDEF);
    add_tok(0, lalr_pkg::CLS_NOISE);
    add_restart();
    add_tok(3, lalr_pkg::CLS_ORDINARY);
    add_tok(4, lalr_pkg::CLS_ORDINARY);
    add_tok(0, lalr_pkg::CLS_ORDINARY);
    add_tok(2, lalr_pkg::CLS_ORDINARY);
    add_tok(9, lalr_pkg::CLS_ORDINARY);
    wait_idle();

    cfg_write(lalr_pkg::CFG_TRIM, 8'd1);
    add_restart();
    add_tok(0, lalr_pkg::CLS_ORDINARY);
    add_tok(9, lalr_pkg::CLS_ORDINARY);
    build_grammar();
    random_sentences(40);
    wait_idle();

    cfg_write(lalr_pkg::CFG_INIT, 8'd255);
    cfg_write(lalr_pkg::CFG_TRIM, 8'd0);
    for (int y = 0; y < 6; y++) add_act(255, y, lalr_pkg::ACT_SHIFT, $urandom_range(7));
    add_restart();
    add_tok(127, lalr_pkg::CLS_ORDINARY);
    random_sentences(35);
    wait_idle();

    // stack overflow run from a self-looping state
    cfg_write(lalr_pkg::CFG_INIT, 8'd200);
    cfg_write(lalr_pkg::CFG_TRIM, 8'd1);
    add_act(200, 1, lalr_pkg::ACT_SHIFT, 200);
    add_restart();
    repeat (66) add_tok(1, lalr_pkg::CLS_ORDINARY);
    wait_idle();

    cfg_write(lalr_pkg::CFG_INIT, 8'($urandom_range(7)));
    cfg_write(lalr_pkg::CFG_TRIM, 8'($urandom_range(1)));
    build_grammar();
    random_sentences(40);
    wait_idle();

    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
